// ===== rtl/smtt_pkg.sv =====
// Shared types and constants of the scaled multi-timer table.
// Used by the sequencer and the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package smtt_pkg;

    localparam int unsigned CNT_W       = 31;
    localparam int unsigned ID_W        = 32;
    localparam int unsigned STEP_W      = 16;
    localparam int unsigned CLS_W       = 2;
    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned EXP_CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int unsigned NUM_CFG     = 5;
    localparam int unsigned CFG_IDX_W   = 3;

    // Request codes.
    localparam logic [2:0] FN_START = 3'd0;
    localparam logic [2:0] FN_STOP  = 3'd1;
    localparam logic [2:0] FN_QUERY = 3'd2;
    localparam logic [2:0] FN_TICK  = 3'd3;
    localparam logic [2:0] FN_SPEED = 3'd4;

    // Result status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_EXPIRED   = 3'd3;
    localparam logic [2:0] ST_NO_EXPIRY = 3'd4;

    // Event classes.
    localparam logic [CLS_W-1:0] CLS_SWITCH  = 2'd0;
    localparam logic [CLS_W-1:0] CLS_EXIT    = 2'd1;
    localparam logic [CLS_W-1:0] CLS_GROUP   = 2'd2;
    localparam logic [CLS_W-1:0] CLS_GENERIC = 2'd3;

    // Class register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_OPEN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_OPEN_LONG = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT             = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_GROUP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_GROUP       = 3'd4;

    typedef struct packed {
        logic [2:0]        func;
        logic [CNT_W-1:0]  start_count;
        logic [ID_W-1:0]   timer_id;
        logic [STEP_W-1:0] step_value;
    } t_in_req;

    typedef struct packed {
        logic [2:0]       status;
        logic [ID_W-1:0]  result_id;
        logic [CNT_W-1:0] remaining;
        logic [CLS_W-1:0] event_class;
        logic             last;
    } t_out_res;

    // One entry of the slot memory.
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] remaining;
        logic [CLS_W-1:0] cls;
    } t_slot;

    localparam int unsigned SLOT_W = $bits(t_slot);

endpackage

`default_nettype wire

// ===== rtl/scaled_multi_timer_table_core.sv =====
// Pool of NUM_TIMERS countdown timers kept in one slot memory. One request is
// handled at a time and the slot memory is walked one slot per cycle through its
// single read port while no result waits on a full result register. A tick with
// a nonzero step walks every slot; a start, stop or query ends its walk at the
// slot it hits (it walks every slot on a miss), and set speed or a tick with step
// zero does no walk. The next request is taken while the last result still
// waits in the result register. Expired timers come out in ascending slot order,
// at most 16 per tick.
// Depends on smtt_pkg, smtt_seq and smtt_ram.
`timescale 1ns / 1ps
`default_nettype none

module scaled_multi_timer_table_core
    import smtt_pkg::*;
#(
    parameter int unsigned NUM_TIMERS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_req              i_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_res                  o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CNT_W-1:0]     i_cfg_data
);

    localparam int unsigned IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    logic [CNT_W-1:0] r_dur [NUM_CFG];
    logic [CLS_W-1:0] start_cls;

    logic             ram_re;
    logic [IW-1:0]    ram_raddr;
    logic             ram_we;
    logic [IW-1:0]    ram_waddr;
    t_slot            ram_wdata;
    t_slot            ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CFG; k++) begin
                r_dur[k] <= '0;
            end
        end else if (i_cfg_we && i_cfg_idx < CFG_IDX_W'(NUM_CFG)) begin
            r_dur[i_cfg_idx] <= i_cfg_data;
        end
    end

    // The class registers are checked in order; the first match wins.
    always_comb begin
        if (i_in.start_count == r_dur[CFG_SWITCH_OPEN] ||
            i_in.start_count == r_dur[CFG_SWITCH_OPEN_LONG]) begin
            start_cls = CLS_SWITCH;
        end else if (i_in.start_count == r_dur[CFG_EXIT]) begin
            start_cls = CLS_EXIT;
        end else if (i_in.start_count == r_dur[CFG_SHORT_GROUP] ||
                     i_in.start_count == r_dur[CFG_LONG_GROUP]) begin
            start_cls = CLS_GROUP;
        end else begin
            start_cls = CLS_GENERIC;
        end
    end

    smtt_seq #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_start_cls (start_cls),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .i_ram_rdata (ram_rdata)
    );

    smtt_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (NUM_TIMERS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

`ifndef SYNTH
    // The walk never reads the slot it writes back in the same cycle.
    a_no_rw_same_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we && ram_re |-> ram_waddr != ram_raddr)
        else $error("slot memory read and write hit the same entry");

    // Slot writes only happen while a request is in progress.
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !ram_we)
        else $error("slot memory written while idle");

    // Only expiries can be followed by more results of the same request.
    a_last_on_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != ST_EXPIRED |-> o_out.last)
        else $error("non-expiry result without last");

    // Failure and quiet results carry no id.
    a_no_id_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == ST_NOT_FOUND || o_out.status == ST_FULL ||
                        o_out.status == ST_NO_EXPIRY) |-> o_out.result_id == '0)
        else $error("id reported on a failed or quiet result");
`endif

endmodule

`default_nettype wire

// ===== rtl/smtt_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// Stand-alone; holds the slot entries of the timer table.
`timescale 1ns / 1ps
`default_nettype none

module smtt_ram #(
    parameter int unsigned WIDTH = 65,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                     i_wdata,
    input  wire logic                                 i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // The read data holds while no read is issued.
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/smtt_seq.sv =====
// Request sequencer of the timer table: walks the slot memory one slot per cycle
// when not stalled on a full result register, keeps the valid bits, the id
// counter, the step and the result register. Needs smtt_pkg; drives one smtt_ram.
`timescale 1ns / 1ps
`default_nettype none

module smtt_seq
    import smtt_pkg::*;
#(
    parameter int unsigned NUM_TIMERS = 16,
    localparam int unsigned IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_req           i_in,
    input  wire logic [CLS_W-1:0]  i_start_cls,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_res               o_out,
    output logic                   o_ram_re,
    output logic [IW-1:0]          o_ram_raddr,
    output logic                   o_ram_we,
    output logic [IW-1:0]          o_ram_waddr,
    output t_slot                  o_ram_wdata,
    input  wire t_slot             i_ram_rdata
);

    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state                r_state, n_state;
    t_in_req               r_req, n_req;
    logic [CLS_W-1:0]      r_cls, n_cls;
    logic [STEP_W-1:0]     r_step, n_step;
    logic [ID_W-1:0]       r_next_id, n_next_id;
    logic [NUM_TIMERS-1:0] r_valid, n_valid;
    logic [IW-1:0]         r_rd_idx, n_rd_idx;
    logic                  r_rd_more, n_rd_more;
    logic                  r_ev_vld, n_ev_vld;
    logic [IW-1:0]         r_ev_idx, n_ev_idx;
    logic [EXP_CNT_W-1:0]  r_cnt, n_cnt;
    logic                  r_pend_vld, n_pend_vld;
    logic [ID_W-1:0]       r_pend_id, n_pend_id;
    logic [CLS_W-1:0]      r_pend_cls, n_pend_cls;
    logic                  r_out_vld, n_out_vld;
    t_out_res              r_out, n_out;

    logic                  out_free;
    logic                  push;
    t_out_res              push_res;
    logic                  stall;
    logic                  slot_live;
    logic [ID_W-1:0]       new_id;
    logic [CNT_W-1:0]      step_ext;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;
    assign out_free    = !r_out_vld || i_out_ready;
    assign slot_live   = r_valid[r_ev_idx];
    assign new_id      = r_next_id + ID_W'(1);
    assign step_ext    = CNT_W'(r_step);

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_cls      = r_cls;
        n_step     = r_step;
        n_next_id  = r_next_id;
        n_valid    = r_valid;
        n_rd_idx   = r_rd_idx;
        n_rd_more  = r_rd_more;
        n_ev_vld   = r_ev_vld;
        n_ev_idx   = r_ev_idx;
        n_cnt      = r_cnt;
        n_pend_vld = r_pend_vld;
        n_pend_id  = r_pend_id;
        n_pend_cls = r_pend_cls;
        push       = 1'b0;
        push_res   = '0;
        stall      = 1'b0;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_rd_idx;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_ev_idx;
        o_ram_wdata = i_ram_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req      = i_in;
                    n_cls      = i_start_cls;
                    n_rd_idx   = '0;
                    n_rd_more  = 1'b1;
                    n_ev_vld   = 1'b0;
                    n_cnt      = '0;
                    n_pend_vld = 1'b0;
                    unique case (i_in.func)
                        FN_START, FN_STOP, FN_QUERY: begin
                            n_state = S_SCAN;
                        end
                        FN_TICK: begin
                            n_state = (r_step != '0) ? S_SCAN : S_FIN;
                        end
                        FN_SPEED: begin
                            n_step  = i_in.step_value;
                            n_state = S_FIN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // Evaluate the slot whose memory word arrived this cycle.
                if (r_ev_vld) begin
                    unique case (r_req.func)
                        FN_START: begin
                            if (!slot_live) begin
                                if (out_free) begin
                                    push                 = 1'b1;
                                    push_res.status      = ST_OK;
                                    push_res.result_id   = new_id;
                                    push_res.last        = 1'b1;
                                    o_ram_we             = 1'b1;
                                    o_ram_wdata.id        = new_id;
                                    o_ram_wdata.remaining = r_req.start_count;
                                    o_ram_wdata.cls       = r_cls;
                                    n_valid[r_ev_idx]    = 1'b1;
                                    n_next_id            = new_id;
                                    n_state              = S_IDLE;
                                end else begin
                                    stall = 1'b1;
                                end
                            end
                        end
                        FN_STOP, FN_QUERY: begin
                            if (slot_live && i_ram_rdata.id == r_req.timer_id) begin
                                if (out_free) begin
                                    push               = 1'b1;
                                    push_res.status    = ST_OK;
                                    push_res.remaining = i_ram_rdata.remaining;
                                    push_res.last      = 1'b1;
                                    if (r_req.func == FN_STOP) begin
                                        n_valid[r_ev_idx] = 1'b0;
                                    end
                                    n_state = S_IDLE;
                                end else begin
                                    stall = 1'b1;
                                end
                            end
                        end
                        FN_TICK: begin
                            if (slot_live) begin
                                if (i_ram_rdata.remaining > step_ext) begin
                                    o_ram_we              = 1'b1;
                                    o_ram_wdata.remaining = i_ram_rdata.remaining - step_ext;
                                end else if (r_cnt < EXP_CNT_W'(MAX_RESULTS)) begin
                                    // The previous expiry is sent only now, once it is
                                    // known not to be the final result of the tick.
                                    if (r_pend_vld && !out_free) begin
                                        stall = 1'b1;
                                    end else begin
                                        push                 = r_pend_vld;
                                        push_res.status      = ST_EXPIRED;
                                        push_res.result_id   = r_pend_id;
                                        push_res.event_class = r_pend_cls;
                                        n_valid[r_ev_idx]    = 1'b0;
                                        n_pend_vld           = 1'b1;
                                        n_pend_id            = i_ram_rdata.id;
                                        n_pend_cls           = i_ram_rdata.cls;
                                        n_cnt                = r_cnt + EXP_CNT_W'(1);
                                    end
                                end else begin
                                    o_ram_we              = 1'b1;
                                    o_ram_wdata.remaining = '0;
                                end
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end

                if (!stall) begin
                    if (r_rd_more) begin
                        o_ram_re  = 1'b1;
                        n_ev_vld  = 1'b1;
                        n_ev_idx  = r_rd_idx;
                        n_rd_idx  = r_rd_idx + IW'(1);
                        n_rd_more = (r_rd_idx != LAST_IDX);
                    end else begin
                        n_ev_vld = 1'b0;
                        if (!r_ev_vld) begin
                            n_state = S_FIN;
                        end
                    end
                end
            end

            S_FIN: begin
                if (out_free) begin
                    push          = 1'b1;
                    push_res.last = 1'b1;
                    unique case (r_req.func)
                        FN_START: begin
                            push_res.status = ST_FULL;
                        end
                        FN_STOP, FN_QUERY: begin
                            push_res.status = ST_NOT_FOUND;
                        end
                        FN_TICK: begin
                            if (r_pend_vld) begin
                                push_res.status      = ST_EXPIRED;
                                push_res.result_id   = r_pend_id;
                                push_res.event_class = r_pend_cls;
                            end else begin
                                push_res.status = ST_NO_EXPIRY;
                            end
                        end
                        default: begin
                            push_res.status = ST_OK;
                        end
                    endcase
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_vld = push ? 1'b1 : (i_out_ready ? 1'b0 : r_out_vld);
        n_out     = push ? push_res : r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= '0;
            r_next_id  <= '0;
            r_valid    <= '0;
            r_rd_more  <= 1'b0;
            r_ev_vld   <= 1'b0;
            r_cnt      <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_next_id  <= n_next_id;
            r_valid    <= n_valid;
            r_rd_more  <= n_rd_more;
            r_ev_vld   <= n_ev_vld;
            r_cnt      <= n_cnt;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_cls      <= n_cls;
        r_rd_idx   <= n_rd_idx;
        r_ev_idx   <= n_ev_idx;
        r_pend_id  <= n_pend_id;
        r_pend_cls <= n_pend_cls;
        r_out      <= n_out;
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for scaled_multi_timer_table_core.
// Mirrors the timer pool in its own state, predicts each result of every accepted
// request and compares it field by field. Depends on smtt_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
    import smtt_pkg::*;

    localparam int NUM_TIMERS    = 16;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 2 * (NUM_TIMERS + 3);
    localparam int PRESSURE_HOLD = 200;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Request codes that the core ignores.
    localparam logic [2:0] FN_UNUSED_LO = 3'd5;
    localparam logic [2:0] FN_UNUSED_HI = 3'd7;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_req              i_in;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_res             o_out;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CNT_W-1:0]     i_cfg_data;

    // Mirror of the timer pool.
    logic              live      [NUM_TIMERS];
    logic [ID_W-1:0]   tmr_id    [NUM_TIMERS];
    logic [ID_W-1:0]   tmr_left  [NUM_TIMERS];
    logic [CLS_W-1:0]  tmr_cls   [NUM_TIMERS];
    logic [ID_W-1:0]   id_counter;
    logic [STEP_W-1:0] tick_step;
    logic [CNT_W-1:0]  class_dur [NUM_CFG];

    t_out_res due_results [$];
    int       mismatch_count;
    bit       in_rush;
    bit       out_rush;
    int       out_hold;

    scaled_multi_timer_table_core #(
        .NUM_TIMERS(NUM_TIMERS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_out_res make_result(logic [2:0] status, logic [ID_W-1:0] id,
                                             logic [CNT_W-1:0] left, logic [CLS_W-1:0] cls,
                                             logic last);
        t_out_res res;
        res.status      = status;
        res.result_id   = id;
        res.remaining   = left;
        res.event_class = cls;
        res.last        = last;
        return res;
    endfunction

    // Appends one predicted result at the tail of the queue.
    function automatic void add_due(t_out_res res);
        due_results.insert(due_results.size(), res);
    endfunction

    // The first matching register wins, in index order.
    function automatic logic [CLS_W-1:0] classify_count(logic [CNT_W-1:0] count);
        if (count == class_dur[CFG_SWITCH_OPEN] || count == class_dur[CFG_SWITCH_OPEN_LONG])
            return CLS_SWITCH;
        if (count == class_dur[CFG_EXIT])
            return CLS_EXIT;
        if (count == class_dur[CFG_SHORT_GROUP] || count == class_dur[CFG_LONG_GROUP])
            return CLS_GROUP;
        return CLS_GENERIC;
    endfunction

    function automatic void apply_request(t_in_req req);
        int       slot;
        int       k;
        int       fired;
        t_out_res held;
        slot  = -1;
        fired = 0;
        case (req.func)
            FN_START: begin
                for (k = NUM_TIMERS - 1; k >= 0; k--) begin
                    if (!live[k]) slot = k;
                end
                if (slot < 0) begin
                    add_due(make_result(ST_FULL, '0, '0, '0, 1'b1));
                end else begin
                    id_counter     = id_counter + 1'b1;
                    live[slot]     = 1'b1;
                    tmr_id[slot]   = id_counter;
                    tmr_left[slot] = {1'b0, req.start_count};
                    tmr_cls[slot]  = classify_count(req.start_count);
                    add_due(make_result(ST_OK, id_counter, '0, '0, 1'b1));
                end
            end
            FN_STOP, FN_QUERY: begin
                for (k = NUM_TIMERS - 1; k >= 0; k--) begin
                    if (live[k] && tmr_id[k] == req.timer_id) slot = k;
                end
                if (slot < 0) begin
                    add_due(make_result(ST_NOT_FOUND, '0, '0, '0, 1'b1));
                end else begin
                    add_due(make_result(ST_OK, '0, tmr_left[slot][CNT_W-1:0], '0, 1'b1));
                    if (req.func == FN_STOP) live[slot] = 1'b0;
                end
            end
            FN_TICK: begin
                if (tick_step != '0) begin
                    for (k = 0; k < NUM_TIMERS; k++) begin
                        if (live[k]) begin
                            if (tmr_left[k] > tick_step) begin
                                tmr_left[k] = tmr_left[k] - tick_step;
                            end else if (fired < MAX_RESULTS) begin
                                // Hold back each expiry so the final one can be marked last.
                                if (fired > 0) add_due(held);
                                held    = make_result(ST_EXPIRED, tmr_id[k], '0, tmr_cls[k], 1'b0);
                                live[k] = 1'b0;
                                fired++;
                            end else begin
                                tmr_left[k] = '0;
                            end
                        end
                    end
                end
                if (fired == 0) begin
                    add_due(make_result(ST_NO_EXPIRY, '0, '0, '0, 1'b1));
                end else begin
                    held.last = 1'b1;
                    add_due(held);
                end
            end
            FN_SPEED: begin
                tick_step = req.step_value;
                add_due(make_result(ST_OK, '0, '0, '0, 1'b1));
            end
            default: begin
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_cfg_we === 1'b1) class_dur[i_cfg_idx] = i_cfg_data;
            if (i_in_valid === 1'b1 && o_in_ready === 1'b1) apply_request(i_in);
        end
    end

    function automatic void check_field(string name, logic [ID_W-1:0] want,
                                        logic [ID_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_out_res want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (due_results.size() == 0) begin
                $error("unexpected result: status %0d, id %0d", o_out.status, o_out.result_id);
                mismatch_count++;
            end else begin
                want = due_results.pop_front();
                check_field("status", ID_W'(want.status), ID_W'(o_out.status));
                check_field("result_id", want.result_id, o_out.result_id);
                check_field("remaining", ID_W'(want.remaining), ID_W'(o_out.remaining));
                check_field("event_class", ID_W'(want.event_class),
                            ID_W'(o_out.event_class));
                check_field("last", ID_W'(want.last), ID_W'(o_out.last));
            end
        end
    end

    // Result side: a random stall before each result, or a long one when asked.
    initial begin : result_sink
        int hold;
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (out_hold > 0) begin
                hold     = out_hold;
                out_hold = 0;
            end else begin
                hold = out_rush ? 0 : $urandom_range(0, 11);
            end
            if (hold > 0) begin
                i_out_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            if ($urandom_range(0, 29) == 0) out_rush = !out_rush;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid === 1'b1 && o_in_ready === 1'b1) ||
                (o_out_valid === 1'b1 && i_out_ready === 1'b1) || i_cfg_we === 1'b1) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic t_in_req make_req(logic [2:0] func);
        t_in_req req;
        req.func        = func;
        req.start_count = CNT_W'($urandom);
        req.timer_id    = $urandom;
        req.step_value  = STEP_W'($urandom);
        return req;
    endfunction

    task automatic send_request(t_in_req req);
        int gap;
        gap = in_rush ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
    endtask

    task automatic launch_timer(logic [CNT_W-1:0] count);
        t_in_req req;
        req             = make_req(FN_START);
        req.start_count = count;
        send_request(req);
    endtask

    task automatic lookup(logic [2:0] func, logic [ID_W-1:0] id);
        t_in_req req;
        req          = make_req(func);
        req.timer_id = id;
        send_request(req);
    endtask

    task automatic change_step(logic [STEP_W-1:0] step);
        t_in_req req;
        req            = make_req(FN_SPEED);
        req.step_value = step;
        send_request(req);
    endtask

    task automatic tick();
        send_request(make_req(FN_TICK));
    endtask

    // Waits until every predicted result has come, then lets an ignored request drain.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_class_regs(logic [CNT_W-1:0] sw_open, logic [CNT_W-1:0] sw_long,
                                   logic [CNT_W-1:0] exit_dur, logic [CNT_W-1:0] grp_short,
                                   logic [CNT_W-1:0] grp_long);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SWITCH_OPEN;
        i_cfg_data <= sw_open;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SWITCH_OPEN_LONG;
        i_cfg_data <= sw_long;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_EXIT;
        i_cfg_data <= exit_dur;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SHORT_GROUP;
        i_cfg_data <= grp_short;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_LONG_GROUP;
        i_cfg_data <= grp_long;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Mostly short counts so that timers expire, some that hit a class register.
    function automatic logic [CNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return CNT_W'($urandom_range(1, 60));
        if (r < 72) return CNT_W'($urandom_range(61, 400));
        if (r < 88) return class_dur[$urandom_range(0, NUM_CFG - 1)];
        if (r < 92) return '0;
        if (r < 97) return CNT_W'($urandom);
        return CNT_MAX;
    endfunction

    // Usually a live timer, sometimes an id not issued yet or any id at all.
    function automatic logic [ID_W-1:0] pick_id();
        int r;
        int k;
        int n;
        r = $urandom_range(0, 9);
        k = $urandom_range(0, NUM_TIMERS - 1);
        if (r < 7) begin
            for (n = 0; n < NUM_TIMERS; n++) begin
                if (live[(k + n) % NUM_TIMERS]) return tmr_id[(k + n) % NUM_TIMERS];
            end
        end
        if (r < 8) return id_counter + 1'b1;
        return $urandom;
    endfunction

    function automatic logic [STEP_W-1:0] pick_step();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return STEP_W'($urandom);
        return STEP_W'($urandom_range(1, 40));
    endfunction

    function automatic t_in_req draw_request();
        t_in_req req;
        int      r;
        r   = $urandom_range(0, 99);
        req = make_req(FN_TICK);
        if (r < 34) begin
            req.func        = FN_START;
            req.start_count = pick_count();
        end else if (r < 58) begin
            req.func = FN_TICK;
        end else if (r < 70) begin
            req.func     = FN_QUERY;
            req.timer_id = pick_id();
        end else if (r < 82) begin
            req.func     = FN_STOP;
            req.timer_id = pick_id();
        end else if (r < 94) begin
            req.func       = FN_SPEED;
            req.step_value = pick_step();
        end else begin
            req.func = 3'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
        end
        return req;
    endfunction

    task automatic test_idle_pool();
        lookup(FN_QUERY, '0);
        lookup(FN_STOP, '1);
        // The step is still zero after reset, so this tick skips the walk and reports no expiry.
        tick();
    endtask

    task automatic test_basic_ops();
        launch_timer('0);
        launch_timer(CNT_MAX);
        lookup(FN_QUERY, 32'd1);
        change_step(16'd1);
        tick();
        lookup(FN_STOP, 32'd2);
        lookup(FN_QUERY, 32'd2);
        send_request(make_req(FN_UNUSED_LO));
        send_request(make_req(FN_UNUSED_HI));
        tick();
        change_step('1);
    endtask

    // Fills every slot, overflows once, then expires the whole pool in one tick.
    task automatic test_full_pool();
        int k;
        for (k = 0; k < NUM_TIMERS; k++) begin
            launch_timer(k < NUM_CFG ? class_dur[k] : CNT_W'($urandom_range(1, 65535)));
        end
        launch_timer(CNT_W'($urandom_range(1, 100)));
        tick();
    endtask

    task automatic test_random_traffic(int count);
        t_in_req req;
        int      sent;
        sent = 0;
        while (sent < count) begin
            req = draw_request();
            send_request(req);
            if (req.func <= FN_SPEED) sent++;
            if ($urandom_range(0, 24) == 0) in_rush = !in_rush;
        end
        in_rush = 1'b0;
    endtask

    // The result side stops for a long while and requests keep coming back to back.
    task automatic test_backpressure();
        int k;
        out_hold = PRESSURE_HOLD;
        in_rush  = 1'b1;
        for (k = 0; k < 30; k++) send_request(draw_request());
        in_rush  = 1'b0;
    endtask

    initial begin
        int k;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in       <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_SWITCH_OPEN;
        i_cfg_data <= '0;
        for (k = 0; k < NUM_TIMERS; k++) begin
            live[k]     = 1'b0;
            tmr_id[k]   = '0;
            tmr_left[k] = '0;
            tmr_cls[k]  = '0;
        end
        for (k = 0; k < NUM_CFG; k++) class_dur[k] = '0;
        id_counter     = '0;
        tick_step      = '0;
        mismatch_count = 0;
        in_rush        = 1'b0;
        out_rush       = 1'b0;
        out_hold       = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_pool();
        test_basic_ops();
        settle();

        // Overlapping values check that the first matching register wins.
        load_class_regs(31'd5, 31'd9, 31'd17, 31'd9, 31'd33);
        test_full_pool();
        test_random_traffic(40);
        test_backpressure();
        settle();

        load_class_regs(CNT_MAX, '0, CNT_MAX, 31'd1, 31'h4000_0000);
        test_random_traffic(30);
        settle();

        load_class_regs(CNT_W'($urandom_range(1, 80)), CNT_W'($urandom_range(1, 80)),
                        CNT_W'($urandom_range(1, 80)), CNT_W'($urandom_range(1, 80)),
                        CNT_W'($urandom_range(1, 80)));
        test_random_traffic(30);
        settle();

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
